// ----- rtl/tpsc_pkg.sv -----
// Shared types for the two-prime-sum check unit.
// Command and status bundles between controller and datapath; no dependencies.
package tpsc_pkg;

   typedef enum logic [1:0] {
      VSEL_N_MINUS_2,
      VSEL_I,
      VSEL_N_MINUS_I
   } vsel_type;

   typedef struct packed {
      logic     load_n;
      logic     init_i;
      logic     inc_i;
      logic     load_v;
      vsel_type vsel;
      logic     init_d;
      logic     step_d;
      logic     div_start;
   } cmd_type;

   typedef struct packed {
      logic n_lt4;
      logic n_lt5;
      logic n_odd;
      logic i_gt_half;
      logic v_le1;
      logic v_eq2;
      logic v_even;
      logic sq_gt_v;
      logic rem_done;
      logic rem_zero;
   } stat_type;

endpackage

// ----- rtl/tpsc_rem.sv -----
// Iterative remainder unit: restoring division, one quotient bit per cycle.
// Standalone; used by tpsc_datapath.
module tpsc_rem #(
   parameter int NUMBER_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUMBER_BITS-1:0] dividend,
   input  logic [NUMBER_BITS-1:0] divisor,
   output logic                   done,
   output logic                   rem_zero
);
   localparam int CW = (NUMBER_BITS > 1) ? $clog2(NUMBER_BITS) : 1;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [NUMBER_BITS:0]   rem_ff, rem_in;
   logic [NUMBER_BITS-1:0] quo_ff, quo_in;
   logic [NUMBER_BITS:0]   shifted;

   always_comb begin
      shifted = {rem_ff[NUMBER_BITS-1:0], quo_ff[NUMBER_BITS-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NUMBER_BITS - 1);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUMBER_BITS-2:0], 1'b0};
         if (shifted >= {1'b0, divisor}) begin
            rem_in = shifted - {1'b0, divisor};
         end else begin
            rem_in = shifted;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);
endmodule

// ----- rtl/tpsc_datapath.sv -----
// Datapath: number, candidate, value under test, divisor and its square.
// Depends on tpsc_pkg and tpsc_rem.
module tpsc_datapath #(
   parameter int NUMBER_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [NUMBER_BITS-1:0] number,
   input  tpsc_pkg::cmd_type      cmd,
   output tpsc_pkg::stat_type     stat
);
   localparam int SQW = NUMBER_BITS + 2;

   logic [NUMBER_BITS-1:0] n_ff, n_in;
   logic [NUMBER_BITS-1:0] i_ff, i_in;
   logic [NUMBER_BITS-1:0] v_ff, v_in;
   logic [NUMBER_BITS-1:0] d_ff, d_in;
   logic [SQW-1:0]         sq_ff, sq_in;
   logic                   rem_done, rem_zero;

   always_comb begin
      n_in  = cmd.load_n ? number : n_ff;
      i_in  = i_ff;
      if (cmd.init_i) begin
         i_in = NUMBER_BITS'(2);
      end else if (cmd.inc_i) begin
         i_in = i_ff + 1'b1;
      end
      v_in = v_ff;
      if (cmd.load_v) begin
         case (cmd.vsel)
            tpsc_pkg::VSEL_N_MINUS_2: v_in = n_ff - NUMBER_BITS'(2);
            tpsc_pkg::VSEL_I:         v_in = i_ff;
            tpsc_pkg::VSEL_N_MINUS_I: v_in = n_ff - i_ff;
            default:                  v_in = v_ff;
         endcase
      end
      d_in  = d_ff;
      sq_in = sq_ff;
      if (cmd.init_d) begin
         d_in  = NUMBER_BITS'(3);
         sq_in = SQW'(9);
      end else if (cmd.step_d) begin
         d_in  = d_ff + NUMBER_BITS'(2);
         sq_in = sq_ff + {d_ff, 2'b00} + SQW'(4);
      end
   end

   always_ff @(posedge clock) begin
      n_ff  <= n_in;
      i_ff  <= i_in;
      v_ff  <= v_in;
      d_ff  <= d_in;
      sq_ff <= sq_in;
   end

   tpsc_rem #(.NUMBER_BITS(NUMBER_BITS)) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (v_ff),
      .divisor  (d_ff),
      .done     (rem_done),
      .rem_zero (rem_zero)
   );

   always_comb begin
      stat.n_lt4     = (n_ff < NUMBER_BITS'(4));
      stat.n_lt5     = (n_ff < NUMBER_BITS'(5));
      stat.n_odd     = n_ff[0];
      stat.i_gt_half = (i_ff > (n_ff >> 1));
      stat.v_le1     = (v_ff <= NUMBER_BITS'(1));
      stat.v_eq2     = (v_ff == NUMBER_BITS'(2));
      stat.v_even    = ~v_ff[0];
      stat.sq_gt_v   = (sq_ff > {2'b00, v_ff});
      stat.rem_done  = rem_done;
      stat.rem_zero  = rem_zero;
   end
endmodule

// ----- rtl/tpsc_ctrl.sv -----
// Controller: sequences candidate scan and trial division, owns the result register.
// Depends on tpsc_pkg.
module tpsc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_is_two_prime_sum,
   output tpsc_pkg::cmd_type  cmd,
   input  tpsc_pkg::stat_type stat
);
   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_CAND,
      S_PTEST,
      S_SQ,
      S_DIV,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      odd_ff, odd_in;
   logic      second_ff, second_in;
   logic      result_ff, result_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_bit_ff, rsp_bit_in;

   always_comb begin
      logic is_prime;
      logic not_prime;
      is_prime     = 1'b0;
      not_prime    = 1'b0;
      state_in     = state_ff;
      odd_in       = odd_ff;
      second_in    = second_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_bit_in   = rsp_bit_ff;
      cmd          = '0;
      cmd.vsel     = tpsc_pkg::VSEL_I;
      req_ready    = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_n = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            odd_in    = stat.n_odd;
            second_in = 1'b0;
            if (stat.n_lt4 || (stat.n_odd && stat.n_lt5)) begin
               result_in = 1'b0;
               state_in  = S_FINISH;
            end else if (stat.n_odd) begin
               cmd.load_v = 1'b1;
               cmd.vsel   = tpsc_pkg::VSEL_N_MINUS_2;
               state_in   = S_PTEST;
            end else begin
               cmd.init_i = 1'b1;
               state_in   = S_CAND;
            end
         end
         S_CAND: begin
            if (stat.i_gt_half) begin
               result_in = 1'b0;
               state_in  = S_FINISH;
            end else begin
               cmd.load_v = 1'b1;
               cmd.vsel   = tpsc_pkg::VSEL_I;
               second_in  = 1'b0;
               state_in   = S_PTEST;
            end
         end
         S_PTEST: begin
            if (stat.v_le1) begin
               not_prime = 1'b1;
            end else if (stat.v_eq2) begin
               is_prime = 1'b1;
            end else if (stat.v_even) begin
               not_prime = 1'b1;
            end else begin
               cmd.init_d = 1'b1;
               state_in   = S_SQ;
            end
         end
         S_SQ: begin
            if (stat.sq_gt_v) begin
               is_prime = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (stat.rem_done) begin
               if (stat.rem_zero) begin
                  not_prime = 1'b1;
               end else begin
                  cmd.step_d = 1'b1;
                  state_in   = S_SQ;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = result_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (is_prime) begin
         if (odd_ff || second_ff) begin
            result_in = 1'b1;
            state_in  = S_FINISH;
         end else begin
            cmd.load_v = 1'b1;
            cmd.vsel   = tpsc_pkg::VSEL_N_MINUS_I;
            second_in  = 1'b1;
            state_in   = S_PTEST;
         end
      end else if (not_prime) begin
         if (odd_ff) begin
            result_in = 1'b0;
            state_in  = S_FINISH;
         end else begin
            cmd.inc_i = 1'b1;
            state_in  = S_CAND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      odd_ff     <= odd_in;
      second_ff  <= second_in;
      result_ff  <= result_in;
      rsp_bit_ff <= rsp_bit_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_is_two_prime_sum = rsp_bit_ff;
endmodule

// ----- rtl/two_prime_sum_check_unit.sv -----
// Latency: data dependent. Each divisor tried runs the bit-serial remainder unit to
// completion; each prime test and each candidate add controller states of their own.
// Numbers below 4 go from the check state straight to finish. Throughput: one item at a
// time; a new item is taken while the previous result waits in the output register.
// Reset: synchronous, clears controller state and output valid; no memory to clear.
module two_prime_sum_check_unit #(
   parameter int NUMBER_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [NUMBER_BITS-1:0] req_number,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_is_two_prime_sum
);
   tpsc_pkg::cmd_type  cmd;
   tpsc_pkg::stat_type stat;

   tpsc_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_is_two_prime_sum (rsp_is_two_prime_sum),
      .cmd                  (cmd),
      .stat                 (stat)
   );

   tpsc_datapath #(.NUMBER_BITS(NUMBER_BITS)) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .number (req_number),
      .cmd    (cmd),
      .stat   (stat)
   );
endmodule

// ----- rtl/tpsc_checker.sv -----
// Port-level checks for two_prime_sum_check_unit, attached by bind.
// Depends on the top level's ports only.
module tpsc_checker #(
   parameter int NUMBER_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [NUMBER_BITS-1:0] req_number,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_is_two_prime_sum
);
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_two_prime_sum))
      else $error("result changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new transfer taken while busy");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_number < 4) && (!rsp_valid || rsp_ready)
      |-> ##3 (rsp_valid && !rsp_is_two_prime_sum))
      else $error("small number did not give a quick zero");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind two_prime_sum_check_unit tpsc_checker #(.NUMBER_BITS(NUMBER_BITS)) u_tpsc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .req_number           (req_number),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_is_two_prime_sum (rsp_is_two_prime_sum)
);
